FILE: rtl/fptp_pkg.sv
// shared constants and codes for the fp16 panel transpose pack unit
// no dependencies; every other file imports this package
package fptp_pkg;

    localparam int GROUP_ROWS = 8;
    localparam int LANE_W     = 16;
    localparam int ROW_W      = 3;
    localparam int DEST_W     = 16;

    // configuration register widths
    localparam int RL_W       = 11;
    localparam int PG_W       = 4;
    localparam int VR_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // reset values of the configuration registers
    localparam int RL_RESET   = 1;
    localparam int PG_RESET   = 4;
    localparam int VR_RESET   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH   = 2'd0,
        REG_PANEL_GROUPS = 2'd1,
        REG_VALID_ROWS   = 2'd2
    } t_reg_idx;

endpackage

FILE: rtl/fptp_if.sv
// channel interfaces of the fp16 panel transpose pack unit
// depends on fptp_pkg
interface fptp_in_if import fptp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LANE_W-1:0] element_value;
    logic              start_panel;

    modport source (output valid, element_value, start_panel, input ready);
    modport sink   (input valid, element_value, start_panel, output ready);
endinterface

interface fptp_out_if import fptp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DEST_W-1:0] dest_word_index;
    logic [LANE_W-1:0] lane_0;
    logic [LANE_W-1:0] lane_1;
    logic [LANE_W-1:0] lane_2;
    logic [LANE_W-1:0] lane_3;
    logic [LANE_W-1:0] lane_4;
    logic [LANE_W-1:0] lane_5;
    logic [LANE_W-1:0] lane_6;
    logic [LANE_W-1:0] lane_7;
    logic              panel_done;

    modport source (output valid, dest_word_index, lane_0, lane_1, lane_2, lane_3,
                    lane_4, lane_5, lane_6, lane_7, panel_done, input ready);
    modport sink   (input valid, dest_word_index, lane_0, lane_1, lane_2, lane_3,
                    lane_4, lane_5, lane_6, lane_7, panel_done, output ready);
endinterface

interface fptp_cfg_if import fptp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/fptp_front.sv
// front end: takes source words, tracks row/column/group position, builds commands
// depends on fptp_pkg and fptp_in_if; command and config types come from the top
module fptp_front import fptp_pkg::*; #(
    parameter int  MAX_ROW_LENGTH = 1024,
    parameter int  MAX_GROUPS     = 8,
    parameter type t_cfg          = logic,
    parameter type t_cmd          = logic
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fptp_in_if.sink   i_in,
    input  t_cfg      i_cfg,
    input  logic      i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    localparam int CW = $clog2(MAX_ROW_LENGTH);
    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    logic [CW-1:0]   r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [GW-1:0]   r_group, n_group;

    logic [CW-1:0]    c0, c_in, col;
    logic [ROW_W-1:0] row0, row_in, last_row;
    logic [GW-1:0]    g0, g_in;
    logic [VR_W-1:0]  pg8, vr_eff, vr_m1, rem;
    logic             past_rows, last_col, is_last_row, is_last_group;
    logic             accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        // effective valid row count, clamped to the panel height
        pg8 = VR_W'({i_cfg.pg, 3'b000});
        if (i_cfg.vr == '0) begin
            vr_eff = VR_W'(1);
        end else if (i_cfg.vr > pg8) begin
            vr_eff = pg8;
        end else begin
            vr_eff = i_cfg.vr;
        end
        vr_m1 = vr_eff - VR_W'(1);

        // start of panel clears position before the word is used
        c0   = i_in.start_panel ? '0 : r_col;
        row0 = i_in.start_panel ? '0 : r_row;
        g0   = i_in.start_panel ? '0 : r_group;

        // group past the valid rows restarts the panel
        past_rows = VR_W'({g0, 3'b000}) >= vr_eff;
        c_in   = past_rows ? '0 : c0;
        row_in = past_rows ? '0 : row0;
        g_in   = past_rows ? '0 : g0;

        rem = vr_eff - VR_W'({g_in, 3'b000});
        if (rem > VR_W'(GROUP_ROWS)) begin
            last_row = ROW_W'(GROUP_ROWS - 1);
        end else begin
            last_row = ROW_W'(rem - VR_W'(1));
        end

        col           = (c_in > i_cfg.rl_m1) ? i_cfg.rl_m1 : c_in;
        last_col      = (col == i_cfg.rl_m1);
        is_last_row   = (row_in >= last_row);
        is_last_group = (g_in >= vr_m1[VR_W-1:3]);
    end

    always_comb begin
        n_col   = last_col ? '0 : col + CW'(1);
        n_row   = row_in;
        n_group = g_in;
        if (last_col) begin
            if (!is_last_row) begin
                n_row = row_in + ROW_W'(1);
            end else begin
                n_row   = '0;
                n_group = is_last_group ? '0 : g_in + GW'(1);
            end
        end
    end

    always_comb begin
        o_cmd.emit     = is_last_row;
        o_cmd.row      = row_in;
        o_cmd.col      = col;
        o_cmd.value    = i_in.element_value;
        o_cmd.last_row = last_row;
        o_cmd.group    = g_in;
        o_cmd.done     = last_col && is_last_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_group <= '0;
        end else if (accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_group <= n_group;
        end
    end

endmodule

FILE: rtl/fptp_queue.sv
// two-entry command queue between front and back end
// depends on fptp_pkg; the entry type comes from the instantiating module
module fptp_queue import fptp_pkg::*; #(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int DEPTH = 2;

    t_item      r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/fptp_back.sv
// back end: line store banks, column read, lane assembly and output register
// depends on fptp_pkg and fptp_out_if; the command type comes from the top
module fptp_back import fptp_pkg::*; #(
    parameter int  MAX_ROW_LENGTH = 1024,
    parameter type t_cmd          = logic
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_cmd_pop,
    input  logic [PG_W-1:0] i_pg,
    fptp_out_if.source      o_out
);

    localparam int CW = $clog2(MAX_ROW_LENGTH);
    localparam int PW = CW + PG_W + 1;

    logic             wr_en, rd_en, s1_adv, s1_free;
    logic [PW-1:0]    col_sum;

    logic [LANE_W-1:0] r_rdata [GROUP_ROWS-1];
    logic              r_s1_valid;
    logic [LANE_W-1:0] r_s1_value;
    logic [ROW_W-1:0]  r_s1_last;
    logic [DEST_W-1:0] r_s1_dest;
    logic              r_s1_done;

    logic              r_out_valid;
    logic [LANE_W-1:0] r_lane [GROUP_ROWS];
    logic [LANE_W-1:0] n_lane [GROUP_ROWS];
    logic [DEST_W-1:0] r_out_dest;
    logic              r_out_done;

    assign s1_adv    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_free   = !r_s1_valid || s1_adv;
    assign o_cmd_pop = i_cmd_valid && (!i_cmd.emit || s1_free);
    assign wr_en     = o_cmd_pop && !i_cmd.emit;
    assign rd_en     = o_cmd_pop && i_cmd.emit;

    // one bank per buffered row, all read at the same column
    for (genvar b = 0; b < GROUP_ROWS - 1; b++) begin : g_bank
        logic [LANE_W-1:0] r_mem [MAX_ROW_LENGTH];

        always_ff @(posedge i_clk) begin
            if (wr_en && i_cmd.row == ROW_W'(b)) begin
                r_mem[i_cmd.col] <= i_cmd.value;
            end
            if (rd_en) begin
                r_rdata[b] <= r_mem[i_cmd.col];
            end
        end
    end

    // destination index: (col * groups + group) * 8
    assign col_sum = PW'(i_cmd.col) * PW'(i_pg) + PW'(i_cmd.group);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_value <= i_cmd.value;
            r_s1_last  <= i_cmd.last_row;
            r_s1_dest  <= DEST_W'({col_sum, 3'b000});
            r_s1_done  <= i_cmd.done;
        end
    end

    always_comb begin
        for (int r = 0; r < GROUP_ROWS - 1; r++) begin
            if (ROW_W'(r) < r_s1_last) begin
                n_lane[r] = r_rdata[r];
            end else if (ROW_W'(r) == r_s1_last) begin
                n_lane[r] = r_s1_value;
            end else begin
                n_lane[r] = '0;
            end
        end
        n_lane[GROUP_ROWS-1] = (r_s1_last == ROW_W'(GROUP_ROWS - 1)) ? r_s1_value : '0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_lane     <= n_lane;
            r_out_dest <= r_s1_dest;
            r_out_done <= r_s1_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.dest_word_index = r_out_dest;
    assign o_out.lane_0          = r_lane[0];
    assign o_out.lane_1          = r_lane[1];
    assign o_out.lane_2          = r_lane[2];
    assign o_out.lane_3          = r_lane[3];
    assign o_out.lane_4          = r_lane[4];
    assign o_out.lane_5          = r_lane[5];
    assign o_out.lane_6          = r_lane[6];
    assign o_out.lane_7          = r_lane[7];
    assign o_out.panel_done      = r_out_done;

endmodule

FILE: rtl/fp16_panel_transpose_pack_unit.sv
// top level: fp16 panel transpose pack, one source word per cycle unless stalled, one column per result
// path: a last-row word passes the queue, the column read register and the output register
// throughput: 1 word per cycle while the output does not stall; the line store banks are single-ported
// reset: synchronous active low; counters clear, registers return to their defaults
// the line store is not cleared; it holds undefined data until written
// depends on fptp_pkg, fptp_if, fptp_front, fptp_queue, fptp_back
module fp16_panel_transpose_pack_unit import fptp_pkg::*; #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_GROUPS     = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fptp_in_if.sink    i_in,
    fptp_out_if.source o_out,
    fptp_cfg_if.sink   i_cfg
);

    localparam int CW = $clog2(MAX_ROW_LENGTH);
    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    // clamped configuration as the front and back see it
    typedef struct packed {
        logic [CW-1:0]   rl_m1;   // row length minus one
        logic [PG_W-1:0] pg;      // groups per panel, already clamped
        logic [VR_W-1:0] vr;      // raw valid row count, clamped in the front
    } t_cfg;

    // one command per source word: buffer a row word, or emit a column
    typedef struct packed {
        logic              emit;
        logic [ROW_W-1:0]  row;
        logic [CW-1:0]     col;
        logic [LANE_W-1:0] value;
        logic [ROW_W-1:0]  last_row;
        logic [GW-1:0]     group;
        logic              done;
    } t_cmd;

    t_cfg r_cfg;
    t_cmd front_cmd, queue_cmd;
    logic push, full, pop, queue_valid;

    logic [RL_W-1:0] wr_rl;
    logic [PG_W-1:0] wr_pg;

    // configuration port never stalls
    assign i_cfg.ready = 1'b1;
    assign wr_rl = i_cfg.data[RL_W-1:0];
    assign wr_pg = i_cfg.data[PG_W-1:0];

    // row length and group count are clamped as they are written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rl_m1 <= CW'(RL_RESET - 1);
            r_cfg.pg    <= PG_W'((PG_RESET > MAX_GROUPS) ? MAX_GROUPS : PG_RESET);
            r_cfg.vr    <= VR_W'(VR_RESET);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ROW_LENGTH: begin
                    if (wr_rl == '0) begin
                        r_cfg.rl_m1 <= '0;
                    end else if (int'(wr_rl) > MAX_ROW_LENGTH) begin
                        r_cfg.rl_m1 <= CW'(MAX_ROW_LENGTH - 1);
                    end else begin
                        r_cfg.rl_m1 <= CW'(wr_rl - RL_W'(1));
                    end
                end
                REG_PANEL_GROUPS: begin
                    if (wr_pg == '0) begin
                        r_cfg.pg <= PG_W'(1);
                    end else if (int'(wr_pg) > MAX_GROUPS) begin
                        r_cfg.pg <= PG_W'(MAX_GROUPS);
                    end else begin
                        r_cfg.pg <= wr_pg;
                    end
                end
                REG_VALID_ROWS: begin
                    r_cfg.vr <= i_cfg.data[VR_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // front: position tracking and word classification
    fptp_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_GROUPS     (MAX_GROUPS),
        .t_cfg          (t_cfg),
        .t_cmd          (t_cmd)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    // short queue lets the input keep flowing while the output stalls
    fptp_queue #(
        .t_item (t_cmd)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_cmd)
    );

    // back: line store writes, column reads, result register
    fptp_back #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .t_cmd          (t_cmd)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (pop),
        .i_pg        (r_cfg.pg),
        .o_out       (o_out)
    );

endmodule

FILE: tb/fp16_panel_transpose_pack_unit_tb.sv
// self-checking testbench for fp16_panel_transpose_pack_unit: streams row-major words,
// predicts every packed column transfer and compares it field by field
// depends on fptp_pkg, the fptp_if channel interfaces and the rtl top level
`timescale 1ns / 1ps

module fp16_panel_transpose_pack_unit_tb;
    import fptp_pkg::*;

    localparam int MAX_ROW_LENGTH = 1024;
    localparam int MAX_GROUPS     = 8;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 400;   // long output back-pressure stretch
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 200;
    localparam int RANDOM_COLUMNS = 48;

    // index 3 decodes to no register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef enum int {SINK_FREE, SINK_HALF, SINK_SPARSE, SINK_MOSTLY} t_sink_mode;

    typedef struct packed {
        logic [LANE_W-1:0] value;
        logic              start;
    } t_source_word;

    typedef struct packed {
        logic [DEST_W-1:0]                  dest;
        logic [GROUP_ROWS-1:0][LANE_W-1:0]  lanes;
        logic                               done;
    } t_packed_column;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fptp_in_if  in_if  ();
    fptp_out_if out_if ();
    fptp_cfg_if cfg_if ();

    fp16_panel_transpose_pack_unit #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_GROUPS     (MAX_GROUPS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // words waiting to be offered, and columns the block still owes us
    t_source_word   source_words [$];
    t_packed_column packed_columns [$];

    // shadow of the block: line store, position counters and register copies
    logic [LANE_W-1:0] line_store [GROUP_ROWS-1][MAX_ROW_LENGTH];
    int                col_count = 0;
    int                row_idx   = 0;
    int                group_idx = 0;
    logic [RL_W-1:0]   reg_row_length   = RL_W'(RL_RESET);
    logic [PG_W-1:0]   reg_panel_groups = PG_W'(PG_RESET);
    logic [VR_W-1:0]   reg_valid_rows   = VR_W'(VR_RESET);

    // run statistics
    int words_accepted    = 0;
    int columns_predicted = 0;
    int columns_checked   = 0;
    int mismatch_count    = 0;
    int reg_writes        = 0;
    int mid_panel_changes = 0;
    int phase_count       = 0;

    // output back-pressure control
    logic       hold_req = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;
    int         segment_left = 0;
    t_sink_mode sink_mode = SINK_FREE;

    // sender burst control
    int burst_left = 1;
    int gap_left   = 0;

    int quiet_cycles = 0;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // skew toward the extremes of the 16-bit word
    function automatic logic [LANE_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            default: return LANE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // advance the shadow by one accepted word; queue a column when the last row lands
    task automatic pack_word(input logic [LANE_W-1:0] value, input logic start);
        int rl, pg, vr, rows_here, last_row, last_group, col;
        bit last_col, at_last_row, at_last_group;
        t_packed_column col_out;
        rl = clamp_int(int'(reg_row_length), 1, MAX_ROW_LENGTH);
        pg = clamp_int(int'(reg_panel_groups), 1, MAX_GROUPS);
        vr = clamp_int(int'(reg_valid_rows), 1, pg * GROUP_ROWS);

        // panel start, or a group left stranded past the valid rows by a register change
        if (start || group_idx * GROUP_ROWS >= vr) begin
            col_count = 0;
            row_idx   = 0;
            group_idx = 0;
        end

        rows_here  = vr - group_idx * GROUP_ROWS;
        if (rows_here > GROUP_ROWS) rows_here = GROUP_ROWS;
        last_row   = rows_here - 1;
        last_group = (vr - 1) / GROUP_ROWS;

        // counters past a shortened row saturate to its last column
        col           = (col_count > rl - 1) ? rl - 1 : col_count;
        last_col      = (col == rl - 1);
        at_last_row   = (row_idx >= last_row);
        at_last_group = (group_idx >= last_group);

        if (!at_last_row) begin
            line_store[row_idx][col] = value;
            if (last_col) begin
                col_count = 0;
                row_idx   = (row_idx + 1) & 7;
            end else begin
                col_count = col + 1;
            end
        end else begin
            col_out.dest = DEST_W'(col * pg * GROUP_ROWS + group_idx * GROUP_ROWS);
            for (int r = 0; r < GROUP_ROWS; r++) begin
                if (r < last_row) col_out.lanes[r] = line_store[r][col];
                else if (r == last_row) col_out.lanes[r] = value;
                else col_out.lanes[r] = '0;
            end
            col_out.done = last_col && at_last_group;
            packed_columns.push_back(col_out);
            columns_predicted++;
            if (last_col) begin
                col_count = 0;
                row_idx   = 0;
                group_idx = at_last_group ? 0 : ((group_idx + 1) & 7);
            end else begin
                col_count = col + 1;
            end
        end
    endtask

    // driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin : source_driver
        t_source_word w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                pack_word(in_if.element_value, in_if.start_panel);
                words_accepted++;
            end
            if (gap_left != 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (source_words.size() != 0) begin
                w = source_words.pop_front();
                in_if.valid         <= 1'b1;
                in_if.element_value <= w.value;
                in_if.start_panel   <= w.start;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 32);
                    // a third of the bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes per segment, plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_if.ready <= 1'b0;
        end else begin
            if (segment_left == 0) begin
                sink_mode    = t_sink_mode'($urandom_range(0, 3));
                segment_left = $urandom_range(8, 80);
            end
            segment_left--;
            case (sink_mode)
                SINK_FREE:   out_if.ready <= 1'b1;
                SINK_HALF:   out_if.ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                default:     out_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic report_field(input string field, input logic [LANE_W-1:0] want_v,
                                input logic [LANE_W-1:0] got_v);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %h got %h", $time, field, want_v, got_v);
    endtask

    // monitor: every output transfer against the oldest predicted column
    always @(posedge i_clk) begin : column_monitor
        t_packed_column got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.dest     = out_if.dest_word_index;
            got.lanes[0] = out_if.lane_0;
            got.lanes[1] = out_if.lane_1;
            got.lanes[2] = out_if.lane_2;
            got.lanes[3] = out_if.lane_3;
            got.lanes[4] = out_if.lane_4;
            got.lanes[5] = out_if.lane_5;
            got.lanes[6] = out_if.lane_6;
            got.lanes[7] = out_if.lane_7;
            got.done     = out_if.panel_done;
            if (packed_columns.size() == 0) begin
                report_field("unexpected column, dest_word_index", '0, got.dest);
            end else begin
                want = packed_columns.pop_front();
                if (got.dest !== want.dest)
                    report_field("dest_word_index", want.dest, got.dest);
                for (int r = 0; r < GROUP_ROWS; r++)
                    if (got.lanes[r] !== want.lanes[r])
                        report_field($sformatf("lane_%0d", r), want.lanes[r], got.lanes[r]);
                if (got.done !== want.done)
                    report_field("panel_done", LANE_W'(want.done), LANE_W'(got.done));
            end
            columns_checked++;
        end
    end

    // watchdog: too long without any transfer on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no transfer for %0d cycles, %0d columns outstanding",
                         $time, quiet_cycles, packed_columns.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [LANE_W-1:0] value, input logic start);
        t_source_word w;
        w.value = value;
        w.start = start;
        source_words.push_back(w);
    endtask

    // random content; start_odds of n asserts start_panel about once in n words
    task automatic queue_words(input int count, input logic start_first, input int start_odds);
        logic s;
        for (int k = 0; k < count; k++) begin
            if (k == 0) s = start_first;
            else s = (start_odds != 0) && ($urandom_range(1, start_odds) == 1);
            push_word(rand_word(), s);
        end
    endtask

    // register write; only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_ROW_LENGTH:   reg_row_length   = value[RL_W-1:0];
            REG_PANEL_GROUPS: reg_panel_groups = value[PG_W-1:0];
            REG_VALID_ROWS:   reg_valid_rows   = value[VR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // wait until every word is in and every column out, then let the pipe empty
    task automatic settle_block();
        while (source_words.size() != 0 || in_if.valid === 1'b1 || packed_columns.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int rl_eff, pg_eff, vr_eff, max_rl, panel_words, panels, n;
        int random_words, random_base;

        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.element_value  = '0;
        in_if.start_panel    = 1'b0;
        out_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = REG_ROW_LENGTH;
        cfg_if.data          = '0;
        random_words         = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: one-word rows, eight rows make the first column, bit extremes
        push_word(16'h0000, 1'b1);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h5555, 1'b0);
        push_word(16'hAAAA, 1'b0);
        push_word(16'h8000, 1'b0);
        push_word(16'h0001, 1'b0);
        push_word(16'h7FFF, 1'b0);
        push_word(16'hFFFE, 1'b0);
        settle_block();

        // partial single group of three rows, two columns, then a wrap into a second panel
        write_reg(REG_UNMAPPED, '1);
        write_reg(REG_ROW_LENGTH, 11'd2);
        write_reg(REG_PANEL_GROUPS, 11'd1);
        write_reg(REG_VALID_ROWS, 11'd3);
        queue_words(6, 1'b1, 0);
        queue_words(6, 1'b0, 0);
        settle_block();

        // zero in every register clamps to one word, one group, one row
        write_reg(REG_ROW_LENGTH, '0);
        write_reg(REG_PANEL_GROUPS, '0);
        write_reg(REG_VALID_ROWS, '0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'h0000, 1'b0);
        push_word(16'h8001, 1'b1);
        push_word(16'h7FFE, 1'b0);
        settle_block();

        // longest row, widest stride, one row: every word is a column, top indexes;
        // the receiver holds off for a long stretch so the block backs up its input
        write_reg(REG_ROW_LENGTH, '1);
        write_reg(REG_PANEL_GROUPS, 11'd8);
        write_reg(REG_VALID_ROWS, 11'd1);
        hold_req <= 1'b1;
        queue_words(MAX_ROW_LENGTH, 1'b1, 0);
        settle_block();

        random_base = columns_predicted;
        while (random_words < RANDOM_WORDS ||
               columns_predicted - random_base < RANDOM_COLUMNS) begin
            phase_count++;
            if (phase_count > 1 && $urandom_range(0, 3) == 0) begin
                // register change in mid-panel; the row never grows past what the
                // line store already holds for the current group
                rl_eff = clamp_int(int'(reg_row_length), 1, MAX_ROW_LENGTH);
                write_reg(REG_VALID_ROWS, CFG_DATA_W'($urandom_range(0, 2047)));
                write_reg(REG_PANEL_GROUPS, CFG_DATA_W'($urandom_range(0, 2047)));
                write_reg(REG_ROW_LENGTH, CFG_DATA_W'($urandom_range(0, rl_eff)));
                n = $urandom_range(1, 40);
                queue_words(n, 1'b0, 0);
                mid_panel_changes++;
            end else begin
                write_reg(REG_PANEL_GROUPS, CFG_DATA_W'($urandom_range(0, 2047)));
                write_reg(REG_VALID_ROWS, CFG_DATA_W'($urandom_range(0, 2047)));
                pg_eff = clamp_int(int'(reg_panel_groups), 1, MAX_GROUPS);
                vr_eff = clamp_int(int'(reg_valid_rows), 1, pg_eff * GROUP_ROWS);
                // keep a panel under a hundred words
                max_rl = clamp_int(80 / vr_eff, 1, MAX_ROW_LENGTH);
                write_reg(REG_ROW_LENGTH, CFG_DATA_W'($urandom_range(0, max_rl)));
                rl_eff = clamp_int(int'(reg_row_length), 1, MAX_ROW_LENGTH);
                panel_words = rl_eff * vr_eff;
                if ($urandom_range(0, 4) == 0) begin
                    // broken stream: truncated panels and stray panel starts
                    n = $urandom_range(1, 2 * panel_words);
                    queue_words(n, 1'b1, 16);
                end else begin
                    // whole panels, later ones entered by wrap or by an explicit start
                    panels = $urandom_range(1, 3);
                    n = 0;
                    for (int p = 0; p < panels; p++) begin
                        queue_words(panel_words, (p == 0) || ($urandom_range(0, 1) == 1), 0);
                        n += panel_words;
                    end
                end
            end
            random_words += n;
            settle_block();
        end

        settle_block();
        $display("run: %0d words in, %0d columns checked, %0d register writes, %0d phases",
                 words_accepted, columns_checked, reg_writes, phase_count);
        $display("run: clamped and full-length rows, partial groups, %0d mid-panel changes",
                 mid_panel_changes);
        $display("run: %0d mismatches", mismatch_count);
        if (mismatch_count == 0 && packed_columns.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fptp_pkg.sv
rtl/fptp_if.sv
rtl/fptp_front.sv
rtl/fptp_queue.sv
rtl/fptp_back.sv
rtl/fp16_panel_transpose_pack_unit.sv
tb/fp16_panel_transpose_pack_unit_tb.sv
